@@ rtl/bmpt_pkg.sv @@
`timescale 1ns / 1ps

package bmpt_pkg;

  // field and register widths
  localparam int unsigned TS_W       = 32;
  localparam int unsigned TRAVEL_W   = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned MOT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // motion codes
  localparam logic [MOT_W-1:0] MOT_STOP  = 2'd0;
  localparam logic [MOT_W-1:0] MOT_UP    = 2'd1;
  localparam logic [MOT_W-1:0] MOT_DOWN  = 2'd2;
  localparam logic [MOT_W-1:0] MOT_STOP2 = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL  = 1'd1;

  localparam logic [TRAVEL_W-1:0] TRAVEL_TIME_RST = 16'd10000;
  localparam logic                IDLE_LEVEL_RST  = 1'b1;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_STEP = 7'd5;

  // floor(x / 5) == (x * 205) >> 10 for x below 128
  localparam logic [7:0]  RECIP5       = 8'd205;
  localparam int unsigned RECIP5_SHIFT = 10;

  typedef struct packed {
    logic start;     // run a bit-serial travel update
    logic load;      // take the timestamp as last change, no update
    logic rising;    // add elapsed time, else subtract
    logic set_last;  // take the timestamp as last change after the update
  } adj_req_t;

  typedef struct packed {
    logic                done;
    logic [TRAVEL_W-1:0] travel;
  } adj_rsp_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] pct;
  } div_rsp_t;

endpackage

@@ rtl/bmpt_in_if.sv @@
`timescale 1ns / 1ps

interface bmpt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      button_select;
  logic                      raw_level;
  logic [bmpt_pkg::TS_W-1:0] now_ms;

  modport source (output valid, output button_select, output raw_level, output now_ms,
                  input ready);
  modport sink (input valid, input button_select, input raw_level, input now_ms,
                output ready);
endinterface

@@ rtl/bmpt_out_if.sv @@
`timescale 1ns / 1ps

interface bmpt_out_if;
  logic                       valid;
  logic                       ready;
  logic [bmpt_pkg::MOT_W-1:0] motion_state;
  logic [bmpt_pkg::PCT_W-1:0] position_percent;
  logic                       state_changed;

  modport source (output valid, output motion_state, output position_percent,
                  output state_changed, input ready);
  modport sink (input valid, input motion_state, input position_percent,
                input state_changed, output ready);
endinterface

@@ rtl/bmpt_adj.sv @@
`timescale 1ns / 1ps

module bmpt_adj (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bmpt_pkg::adj_req_t                  req_i,
  input  logic [bmpt_pkg::TS_W-1:0]           now_i,
  input  logic [bmpt_pkg::TRAVEL_W-1:0]       travel_i,
  input  logic [bmpt_pkg::TRAVEL_W-1:0]       ttime_i,
  output bmpt_pkg::adj_rsp_t                  rsp_o
);

  logic                          busy_q, fin_q;
  logic [4:0]                    cnt_q;
  logic [bmpt_pkg::TS_W-1:0]     now_q, last_q;
  logic [bmpt_pkg::TRAVEL_W-1:0] sum_q;
  logic                          hi_q, cy_q, bw_q, rising_q, set_last_q;

  logic n_bit, l_bit, el_bit, bw_d, t_bit, s_bit, cy_d;
  logic over_t;
  logic [bmpt_pkg::TRAVEL_W-1:0] clamp;

  // elapsed = now - last, one bit a cycle, lsb first
  assign n_bit  = now_q[0];
  assign l_bit  = last_q[0];
  assign el_bit = n_bit ^ l_bit ^ bw_q;
  assign bw_d   = (~n_bit & l_bit) | (~(n_bit ^ l_bit) & bw_q);

  // travel +/- elapsed, travel zero above bit 15
  assign t_bit = ~cnt_q[4] & travel_i[cnt_q[3:0]];
  assign s_bit = t_bit ^ el_bit ^ cy_q;
  assign cy_d  = rising_q ? ((t_bit & el_bit) | (t_bit & cy_q) | (el_bit & cy_q))
                          : ((~t_bit & el_bit) | (~(t_bit ^ el_bit) & cy_q));

  assign over_t = (sum_q > ttime_i);

  always_comb begin
    if (!rising_q && cy_q) begin
      clamp = '0;
    end else if ((rising_q && (hi_q || cy_q)) || over_t) begin
      clamp = ttime_i;
    end else begin
      clamp = sum_q;
    end
  end

  assign rsp_o.done   = fin_q;
  assign rsp_o.travel = clamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      fin_q      <= 1'b0;
      cnt_q      <= '0;
      now_q      <= '0;
      last_q     <= '0;
      sum_q      <= '0;
      hi_q       <= 1'b0;
      cy_q       <= 1'b0;
      bw_q       <= 1'b0;
      rising_q   <= 1'b0;
      set_last_q <= 1'b0;
    end else begin
      fin_q <= 1'b0;
      if (req_i.load) begin
        last_q <= now_i;
      end
      if (req_i.start) begin
        busy_q     <= 1'b1;
        cnt_q      <= '0;
        now_q      <= now_i;
        hi_q       <= 1'b0;
        cy_q       <= 1'b0;
        bw_q       <= 1'b0;
        rising_q   <= req_i.rising;
        set_last_q <= req_i.set_last;
      end else if (busy_q) begin
        // both words rotate, so they are whole again when the run finishes
        now_q  <= {n_bit, now_q[bmpt_pkg::TS_W-1:1]};
        last_q <= {l_bit, last_q[bmpt_pkg::TS_W-1:1]};
        bw_q   <= bw_d;
        cy_q   <= cy_d;
        if (!cnt_q[4]) begin
          sum_q <= {s_bit, sum_q[bmpt_pkg::TRAVEL_W-1:1]};
        end else begin
          hi_q <= hi_q | s_bit;
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q && set_last_q) begin
        last_q <= now_q;
      end
    end
  end

endmodule

@@ rtl/bmpt_div.sv @@
`timescale 1ns / 1ps

module bmpt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bmpt_pkg::TRAVEL_W-1:0] travel_i,
  input  logic [bmpt_pkg::TRAVEL_W-1:0] ttime_i,
  output bmpt_pkg::div_rsp_t            rsp_o
);

  localparam int unsigned NUM_W = bmpt_pkg::TRAVEL_W + bmpt_pkg::PCT_W;
  localparam int unsigned PRD_W = bmpt_pkg::PCT_W + 8;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIV  = 2'd1;
  localparam logic [1:0] P_RND  = 2'd2;

  logic [1:0]                 phase_q;
  logic [2:0]                 cnt_q;
  logic [NUM_W-1:0]           num_q, dvs_q, diff;
  logic [bmpt_pkg::PCT_W-1:0] quo_q, pct_q;
  logic                       zero_q, done_q, ge;

  logic [bmpt_pkg::PCT_W-1:0] raw, mul5, rem7, rounded;
  logic [PRD_W-1:0]           prod;
  logic [4:0]                 q5;
  logic [2:0]                 rem;

  assign ge   = (num_q >= dvs_q);
  assign diff = num_q - dvs_q;

  // round to a multiple of 5, remainder above 2 rounds up
  assign raw  = zero_q ? '0 : quo_q;
  assign prod = PRD_W'(raw) * PRD_W'(bmpt_pkg::RECIP5);
  assign q5   = prod[bmpt_pkg::RECIP5_SHIFT +: 5];
  assign mul5 = {q5, 2'b00} + bmpt_pkg::PCT_W'(q5);
  assign rem7 = raw - mul5;
  assign rem  = rem7[2:0];

  always_comb begin
    if (rem > 3'd2) begin
      rounded = raw + bmpt_pkg::PCT_STEP - bmpt_pkg::PCT_W'(rem);
    end else begin
      rounded = raw - bmpt_pkg::PCT_W'(rem);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.pct  = pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
      num_q   <= '0;
      dvs_q   <= '0;
      quo_q   <= '0;
      zero_q  <= 1'b0;
      pct_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        P_IDLE: begin
          if (start_i) begin
            num_q   <= NUM_W'(travel_i) * NUM_W'(bmpt_pkg::PCT_FULL);
            dvs_q   <= {1'b0, ttime_i, 6'b0};
            zero_q  <= (ttime_i == '0);
            cnt_q   <= '0;
            phase_q <= P_DIV;
          end
        end
        P_DIV: begin
          // restoring division, one quotient bit a cycle
          if (ge) begin
            num_q <= diff;
          end
          quo_q <= {quo_q[bmpt_pkg::PCT_W-2:0], ge};
          dvs_q <= {1'b0, dvs_q[NUM_W-1:1]};
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd6) begin
            phase_q <= P_RND;
          end
        end
        P_RND: begin
          pct_q   <= rounded;
          done_q  <= 1'b1;
          phase_q <= P_IDLE;
        end
        default: begin
          phase_q <= P_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/blind_motion_position_tracker.sv @@
`timescale 1ns / 1ps
// latency: a word that leaves the travel time alone is registered at the accepting edge
// and shows from that edge on; a word that stops the blind shows once the divider is done
// per such word: accept, the bit-serial elapsed/travel adder, clamp and multiply, the
// restoring divider, rounding and output; no new word is accepted until it is done
// reset: asynchronous active low; motion stop, travel and position 0, registers default

module blind_motion_position_tracker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  bmpt_in_if.sink                                in_if,
  bmpt_out_if.source                             out_if,
  input  logic                                   cfg_we_i,
  input  logic [bmpt_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [bmpt_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADJ  = 2'd1;  // serial travel update running
  localparam logic [1:0] S_DIV  = 2'd2;  // percent division running

  logic [1:0] state_q;

  // configuration
  logic [bmpt_pkg::TRAVEL_W-1:0] ttime_q;
  logic                          idle_q;

  // blind state
  logic                          up_q, down_q, moving_q;
  logic [bmpt_pkg::MOT_W-1:0]    motion_q, prior_q;
  logic [bmpt_pkg::TRAVEL_W-1:0] travel_q;
  logic [bmpt_pkg::PCT_W-1:0]    pos_q;

  // output register
  logic                          ov_q, out_chg_q;
  logic [bmpt_pkg::MOT_W-1:0]    out_mot_q;
  logic [bmpt_pkg::PCT_W-1:0]    out_pct_q;

  logic                       accept, out_take, pressed, up_n, down_n;
  logic [bmpt_pkg::MOT_W-1:0] st_n;
  logic                       changed, is_stop, do_adj, rising, set_last;

  bmpt_pkg::adj_req_t adj_req;
  bmpt_pkg::adj_rsp_t adj_rsp;
  bmpt_pkg::div_rsp_t div_rsp;

  // a new word is taken when the sequencer is idle and the result slot is free or drains this cycle
  assign in_if.ready = (state_q == S_IDLE) & (~ov_q | out_if.ready);
  assign accept      = in_if.valid & in_if.ready;
  assign out_take    = ov_q & out_if.ready;

  // button flags
  assign pressed = (in_if.raw_level != idle_q);
  assign up_n    = in_if.button_select ? up_q : pressed;
  assign down_n  = in_if.button_select ? pressed : down_q;

  // motion machine; down wins when both are pressed from stop
  always_comb begin
    st_n = motion_q;
    case (motion_q)
      bmpt_pkg::MOT_STOP: begin
        if (down_n) begin
          st_n = bmpt_pkg::MOT_DOWN;
        end else if (up_n) begin
          st_n = bmpt_pkg::MOT_UP;
        end
      end
      bmpt_pkg::MOT_UP: begin
        if (!up_n && !down_n) begin
          st_n = bmpt_pkg::MOT_STOP;
        end else if (!up_n && down_n) begin
          st_n = bmpt_pkg::MOT_STOP2;
        end
      end
      bmpt_pkg::MOT_DOWN: begin
        if (!up_n && !down_n) begin
          st_n = bmpt_pkg::MOT_STOP;
        end else if (up_n && !down_n) begin
          st_n = bmpt_pkg::MOT_STOP2;
        end
      end
      default: begin
        if (!up_n && !down_n) begin
          st_n = bmpt_pkg::MOT_STOP;
        end
      end
    endcase
  end

  assign changed = (st_n != motion_q);
  assign is_stop = (st_n == bmpt_pkg::MOT_STOP) || (st_n == bmpt_pkg::MOT_STOP2);

  // stopping settles the run that just ended; starting only stamps the time
  assign do_adj   = changed & (is_stop ? ((prior_q == bmpt_pkg::MOT_UP) ||
                                          (prior_q == bmpt_pkg::MOT_DOWN))
                                       : moving_q);
  assign rising   = is_stop ? (prior_q == bmpt_pkg::MOT_UP) : (st_n == bmpt_pkg::MOT_UP);
  assign set_last = changed & ~is_stop;

  assign adj_req.start    = accept & do_adj;
  assign adj_req.load     = accept & set_last & ~do_adj;
  assign adj_req.rising   = rising;
  assign adj_req.set_last = set_last;

  bmpt_adj u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (adj_req),
    .now_i    (in_if.now_ms),
    .travel_i (travel_q),
    .ttime_i  (ttime_q),
    .rsp_o    (adj_rsp)
  );

  // clamped travel goes straight to the divider
  bmpt_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (adj_rsp.done),
    .travel_i (adj_rsp.travel),
    .ttime_i  (ttime_q),
    .rsp_o    (div_rsp)
  );

  assign out_if.valid            = ov_q;
  assign out_if.motion_state     = out_mot_q;
  assign out_if.position_percent = out_pct_q;
  assign out_if.state_changed    = out_chg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ttime_q   <= bmpt_pkg::TRAVEL_TIME_RST;
      idle_q    <= bmpt_pkg::IDLE_LEVEL_RST;
      up_q      <= 1'b0;
      down_q    <= 1'b0;
      moving_q  <= 1'b0;
      motion_q  <= bmpt_pkg::MOT_STOP;
      prior_q   <= bmpt_pkg::MOT_STOP;
      travel_q  <= '0;
      pos_q     <= '0;
      ov_q      <= 1'b0;
      out_chg_q <= 1'b0;
      out_mot_q <= bmpt_pkg::MOT_STOP;
      out_pct_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bmpt_pkg::REG_TRAVEL_TIME: ttime_q <= cfg_data_i;
          bmpt_pkg::REG_IDLE_LEVEL:  idle_q  <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_take) begin
        ov_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            up_q     <= up_n;
            down_q   <= down_n;
            motion_q <= st_n;
            if (changed) begin
              prior_q  <= st_n;
              moving_q <= ~is_stop;
            end
            if (do_adj) begin
              state_q <= S_ADJ;
            end else begin
              // position unchanged, word is ready now
              ov_q      <= 1'b1;
              out_mot_q <= st_n;
              out_pct_q <= pos_q;
              out_chg_q <= changed;
            end
          end
        end
        S_ADJ: begin
          if (adj_rsp.done) begin
            travel_q <= adj_rsp.travel;
            state_q  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            pos_q     <= div_rsp.pct;
            ov_q      <= 1'b1;
            out_mot_q <= motion_q;
            out_pct_q <= div_rsp.pct;
            out_chg_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/bmpt_checker.sv @@
`timescale 1ns / 1ps

module bmpt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bmpt_pkg::MOT_W-1:0] motion_state,
  input logic [bmpt_pkg::PCT_W-1:0] position_percent,
  input logic                       state_changed
);

  // a stalled word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(motion_state) && $stable(position_percent)
                                && $stable(state_changed))
    else $error("output word changed while stalled");

  // percent never above full open
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> position_percent <= bmpt_pkg::PCT_FULL)
    else $error("position percent above 100");

  // no word taken while the result slot is blocked
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> !(out_valid && !out_ready))
    else $error("input taken while output stalled");

endmodule

bind blind_motion_position_tracker bmpt_checker u_bmpt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .motion_state     (out_if.motion_state),
  .position_percent (out_if.position_percent),
  .state_changed    (out_if.state_changed)
);
